// File: src/mfc_pkg.sv
// ----------------------------------------------------------------------------
// mfc_pkg: MAVLink v2 frame checker shared definitions
// Configuration layout, result word layout, register indexes and CRC step.
// ----------------------------------------------------------------------------
package mfc_pkg;

  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [7:0]  START_BYTE = 8'hFD;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;

  typedef logic [2:0] reg_index_t;

  localparam reg_index_t REG_MSG_ID_A    = 3'd0;
  localparam reg_index_t REG_CRC_EXTRA_A = 3'd1;
  localparam reg_index_t REG_MSG_ID_B    = 3'd2;
  localparam reg_index_t REG_CRC_EXTRA_B = 3'd3;
  localparam reg_index_t REG_MSG_ID_C    = 3'd4;
  localparam reg_index_t REG_CRC_EXTRA_C = 3'd5;

  typedef logic [1:0] slot_t;

  localparam slot_t SLOT_A = 2'd0;
  localparam slot_t SLOT_B = 2'd1;
  localparam slot_t SLOT_C = 2'd2;

  typedef struct packed {
    logic [23:0] msg_id_a;
    logic [7:0]  crc_extra_a;
    logic [23:0] msg_id_b;
    logic [7:0]  crc_extra_b;
    logic [23:0] msg_id_c;
    logic [7:0]  crc_extra_c;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    slot_t      msg_slot;
    logic [7:0] byte_index;
    logic       frame_end;
    logic       frame_good;
  } result_t;

  // CRC-16/MCRF4XX, one byte, reflected poly 0x8408
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

// File: src/mfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// mfc_cfg_regs: configuration registers
// Accepted message ids and their CRC extra bytes, written by index.
// ----------------------------------------------------------------------------
module mfc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  mfc_pkg::reg_index_t                cfg_index,
  input  logic [mfc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output mfc_pkg::cfg_t                      cfg
);
  import mfc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.msg_id_a    <= 24'd19;
      cfg.crc_extra_a <= 8'd110;
      cfg.msg_id_b    <= 24'd16;
      cfg.crc_extra_b <= 8'd74;
      cfg.msg_id_c    <= 24'd17;
      cfg.crc_extra_c <= 8'd99;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MSG_ID_A:    cfg.msg_id_a    <= cfg_wdata[23:0];
        REG_CRC_EXTRA_A: cfg.crc_extra_a <= cfg_wdata[7:0];
        REG_MSG_ID_B:    cfg.msg_id_b    <= cfg_wdata[23:0];
        REG_CRC_EXTRA_B: cfg.crc_extra_b <= cfg_wdata[7:0];
        REG_MSG_ID_C:    cfg.msg_id_c    <= cfg_wdata[23:0];
        REG_CRC_EXTRA_C: cfg.crc_extra_c <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

// File: src/mfc_parser.sv
// ----------------------------------------------------------------------------
// mfc_parser: frame state machine and CRC
// Tracks frame phase, header fields and running CRC; one byte per step.
// ----------------------------------------------------------------------------
module mfc_parser (
  input  logic              clk,
  input  logic              rst,
  input  mfc_pkg::cfg_t     cfg,
  input  logic              step,
  input  logic [7:0]        rx,
  output logic              res_valid,
  output mfc_pkg::result_t  res
);
  import mfc_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_LO  = 3'd3,
    PH_CRC_HI  = 3'd4
  } phase_t;

  phase_t      phase, phase_next;
  logic [3:0]  header_count, header_count_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [23:0] message_id, message_id_next;
  logic        known, known_next;
  slot_t       slot, slot_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  crc_low, crc_low_next;

  logic [15:0] crc_upd;
  logic [15:0] crc_fin;
  logic [7:0]  extra;
  logic [23:0] id_full;
  logic [7:0]  pc_inc;
  logic        hit_a, hit_b, hit_c;

  always_comb begin
    crc_upd = crc_step(crc, rx);
    id_full = {rx, message_id[15:0]};
    hit_a   = (id_full == cfg.msg_id_a);
    hit_b   = (id_full == cfg.msg_id_b);
    hit_c   = (id_full == cfg.msg_id_c);
    pc_inc  = payload_count + 8'd1;
    case (slot)
      SLOT_A:  extra = cfg.crc_extra_a;
      SLOT_B:  extra = cfg.crc_extra_b;
      default: extra = cfg.crc_extra_c;
    endcase
    crc_fin = crc_step(crc, extra);
  end

  always_comb begin
    phase_next          = phase;
    header_count_next   = header_count;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    message_id_next     = message_id;
    known_next          = known;
    slot_next           = slot;
    crc_next            = crc;
    crc_low_next        = crc_low;
    res_valid           = 1'b0;
    res                 = '0;
    case (phase)
      PH_HEADER: begin
        crc_next = crc_upd;
        case (header_count)
          4'd0:    payload_length_next = rx;
          4'd6:    message_id_next = {16'h0000, rx};
          4'd7:    message_id_next = {8'h00, rx, message_id[7:0]};
          4'd8:    message_id_next = id_full;
          default: ;
        endcase
        if (header_count >= 4'd8) begin
          header_count_next  = 4'd0;
          payload_count_next = 8'd0;
          known_next         = hit_a | hit_b | hit_c;
          if (hit_a)      slot_next = SLOT_A;
          else if (hit_b) slot_next = SLOT_B;
          else if (hit_c) slot_next = SLOT_C;
          else            slot_next = SLOT_A;
          phase_next = (payload_length == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
        end else begin
          header_count_next = header_count + 4'd1;
        end
      end
      PH_PAYLOAD: begin
        crc_next           = crc_upd;
        payload_count_next = pc_inc;
        if (pc_inc == payload_length) phase_next = PH_CRC_LO;
        res_valid          = known;
        res.out_byte       = rx;
        res.msg_slot       = slot;
        res.byte_index     = payload_count;
      end
      PH_CRC_LO: begin
        crc_low_next = rx;
        phase_next   = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        phase_next     = PH_HUNT;
        res_valid      = known;
        res.msg_slot   = slot;
        res.byte_index = payload_length;
        res.frame_end  = 1'b1;
        res.frame_good = (crc_fin == {rx, crc_low});
      end
      default: begin
        phase_next = PH_HUNT;
        if (rx == START_BYTE) begin
          phase_next          = PH_HEADER;
          header_count_next   = 4'd0;
          crc_next            = CRC_INIT;
          message_id_next     = 24'd0;
          payload_length_next = 8'd0;
          payload_count_next  = 8'd0;
          known_next          = 1'b0;
          slot_next           = SLOT_A;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      header_count   <= 4'd0;
      payload_length <= 8'd0;
      payload_count  <= 8'd0;
      message_id     <= 24'd0;
      known          <= 1'b0;
      slot           <= SLOT_A;
      crc            <= CRC_INIT;
      crc_low        <= 8'd0;
    end else if (step) begin
      phase          <= phase_next;
      header_count   <= header_count_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      message_id     <= message_id_next;
      known          <= known_next;
      slot           <= slot_next;
      crc            <= crc_next;
      crc_low        <= crc_low_next;
    end
  end

`ifndef SYNTHESIS
  a_crc_hi_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_CRC_HI |=> phase == PH_HUNT)
    else $error("phase did not return to hunt after CRC high byte");

  a_result_needs_known: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> known)
    else $error("result word from an unknown frame");

  a_header_count_range: assert property (@(posedge clk) disable iff (rst)
    header_count <= 4'd8)
    else $error("header count out of range");

  a_end_only_in_crc_hi: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.frame_end |-> phase == PH_CRC_HI)
    else $error("end marker outside CRC high byte");

  a_payload_no_slot_three: assert property (@(posedge clk) disable iff (rst)
    known |-> slot != 2'd3)
    else $error("invalid slot on known frame");
`endif

endmodule

// File: src/mavlink2_frame_checker_unit.sv
// Flow: an accepted byte is registered in s1_byte and stepped through the
// parser once the output register is free; any result word is then registered
// in out_res. Throughput: one byte per cycle while the output register is free;
// while a word waits for out_ready, an empty input register can take one byte.
// Reset: rst is synchronous active high; phase returns to hunting for 0xFD,
// CRC to 0xFFFF and the configuration registers to their default ids.
// ----------------------------------------------------------------------------
// mavlink2_frame_checker_unit: MAVLink v2 frame checker top level
// Input and output registers around the frame parser, plus config registers.
// ----------------------------------------------------------------------------
module mavlink2_frame_checker_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  mfc_pkg::reg_index_t             cfg_index,
  input  logic [mfc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte,
  output mfc_pkg::slot_t                  msg_slot,
  output logic [7:0]                      byte_index,
  output logic                            frame_end,
  output logic                            frame_good
);
  import mfc_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       proc;
  logic       out_free;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  mfc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mfc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (proc),
    .rx        (s1_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_free = !out_valid || out_ready;
  assign proc     = s1_valid && out_free;
  assign in_ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (out_free) out_valid <= proc && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_byte <= rx_byte;
    if (proc && res_valid) out_res <= res;
  end

  assign out_byte   = out_res.out_byte;
  assign msg_slot   = out_res.msg_slot;
  assign byte_index = out_res.byte_index;
  assign frame_end  = out_res.frame_end;
  assign frame_good = out_res.frame_good;

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: MAVLink v2 frame checker testbench
// Drives a received byte stream of well-formed, corrupt, unknown and cut-off
// frames through the checker under bursty input and a stalling output. A
// scoreboard parses the same stream and checks every payload and end word.
// ----------------------------------------------------------------------------
module tb;
  import mfc_pkg::*;

  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES     = 8;
  localparam int          PHASE_BYTES      = 270;
  localparam reg_index_t  REG_SPARE_6      = 3'd6;
  localparam reg_index_t  REG_SPARE_7      = 3'd7;

  typedef enum logic [2:0] {
    PH_HUNT, PH_HEADER, PH_PAYLOAD, PH_CRC_LO, PH_CRC_HI
  } parse_phase_t;

  class deframe_scoreboard;
    cfg_t         cfg;
    parse_phase_t phase;
    logic [3:0]   hdr_cnt;
    logic [7:0]   pay_len;
    logic [7:0]   pay_cnt;
    logic [23:0]  msg_id;
    logic         known;
    slot_t        slot;
    logic [15:0]  crc;
    logic [7:0]   crc_lo;
    result_t      pending_words[$];
    int           errors;

    function new();
      // power-on ids and extras
      cfg = '{msg_id_a: 24'd19, crc_extra_a: 8'd110, msg_id_b: 24'd16,
              crc_extra_b: 8'd74, msg_id_c: 24'd17, crc_extra_c: 8'd99};
      phase   = PH_HUNT;
      hdr_cnt = '0;
      pay_len = '0;
      pay_cnt = '0;
      msg_id  = '0;
      known   = 1'b0;
      slot    = SLOT_A;
      crc     = CRC_INIT;
      crc_lo  = '0;
      errors  = 0;
    endfunction

    static function logic [15:0] crc16_mcrf4xx(logic [15:0] c_in, logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
      return c;
    endfunction

    function void queue_word(result_t w);
      pending_words.insert(pending_words.size(), w);
    endfunction

    function void write_reg(reg_index_t idx, logic [23:0] d);
      case (idx)
        REG_MSG_ID_A:    cfg.msg_id_a    = d;
        REG_CRC_EXTRA_A: cfg.crc_extra_a = d[7:0];
        REG_MSG_ID_B:    cfg.msg_id_b    = d;
        REG_CRC_EXTRA_B: cfg.crc_extra_b = d[7:0];
        REG_MSG_ID_C:    cfg.msg_id_c    = d;
        REG_CRC_EXTRA_C: cfg.crc_extra_c = d[7:0];
        default: ;
      endcase
    endfunction

    function void take_rx_byte(logic [7:0] b);
      logic [7:0]  idx;
      logic [7:0]  extra;
      logic [15:0] calc;
      case (phase)
        PH_HEADER: begin
          crc = crc16_mcrf4xx(crc, b);
          case (hdr_cnt)
            4'd0: pay_len = b;
            4'd6: msg_id = {16'h0000, b};
            4'd7: msg_id[15:8] = b;
            4'd8: msg_id[23:16] = b;
            default: ;
          endcase
          if (hdr_cnt >= 4'd8) begin
            hdr_cnt = '0;
            known   = 1'b1;
            if (msg_id == cfg.msg_id_a) slot = SLOT_A;
            else if (msg_id == cfg.msg_id_b) slot = SLOT_B;
            else if (msg_id == cfg.msg_id_c) slot = SLOT_C;
            else begin
              known = 1'b0;
              slot  = SLOT_A;
            end
            pay_cnt = '0;
            phase   = (pay_len == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
          end else begin
            hdr_cnt = hdr_cnt + 4'd1;
          end
        end
        PH_PAYLOAD: begin
          idx     = pay_cnt;
          crc     = crc16_mcrf4xx(crc, b);
          pay_cnt = pay_cnt + 8'd1;
          if (pay_cnt == pay_len) phase = PH_CRC_LO;
          if (known)
            queue_word('{out_byte: b, msg_slot: slot, byte_index: idx,
                         frame_end: 1'b0, frame_good: 1'b0});
        end
        PH_CRC_LO: begin
          crc_lo = b;
          phase  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          phase = PH_HUNT;
          if (known) begin
            extra = (slot == SLOT_A) ? cfg.crc_extra_a :
                    (slot == SLOT_B) ? cfg.crc_extra_b : cfg.crc_extra_c;
            calc  = crc16_mcrf4xx(crc, extra);
            queue_word('{out_byte: 8'h00, msg_slot: slot, byte_index: pay_len,
                         frame_end: 1'b1, frame_good: (calc == {b, crc_lo})});
          end
        end
        default: begin
          phase = PH_HUNT;
          if (b == START_BYTE) begin
            phase   = PH_HEADER;
            hdr_cnt = '0;
            crc     = CRC_INIT;
            msg_id  = '0;
            pay_len = '0;
            pay_cnt = '0;
            known   = 1'b0;
            slot    = SLOT_A;
          end
        end
      endcase
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_byte %0d msg_slot %0d byte_index %0d frame_end %0d",
               got.out_byte, got.msg_slot, got.byte_index, got.frame_end);
        errors++;
        return;
      end
      want = pending_words.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0d, actual %0d", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.msg_slot !== want.msg_slot) begin
        $error("msg_slot: expected %0d, actual %0d", want.msg_slot, got.msg_slot);
        errors++;
      end
      if (got.byte_index !== want.byte_index) begin
        $error("byte_index: expected %0d, actual %0d", want.byte_index, got.byte_index);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
        errors++;
      end
      if (got.frame_good !== want.frame_good) begin
        $error("frame_good: expected %0d, actual %0d", want.frame_good, got.frame_good);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  reg_index_t            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            out_byte;
  slot_t                 msg_slot;
  logic [7:0]            byte_index;
  logic                  frame_end;
  logic                  frame_good;

  deframe_scoreboard sb = new();
  int  bytes_sent = 0;
  int  burst_left = 0;
  bit  hold_req   = 1'b0;

  mavlink2_frame_checker_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .msg_slot   (msg_slot),
    .byte_index (byte_index),
    .frame_end  (frame_end),
    .frame_good (frame_good)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.take_rx_byte(rx_byte);
    if (!rst && out_valid && out_ready)
      sb.check_word(result_t'{out_byte, msg_slot, byte_index, frame_end, frame_good});
  end

  // receiver: stretches of steady, sparse, dense and periodic readiness
  initial begin : receiver
    int mode;
    int run;
    int tick;
    tick = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(10, 120);
      repeat (run) begin
        if (hold_req) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
        end
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 3 == 0);
        endcase
        tick++;
        @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  // cut < 0 or past the end sends the whole frame, otherwise only its first cut bytes
  task automatic send_frame(input logic [23:0] id, input int len, input bit bad_crc,
                            input int cut, input bit start_inside);
    logic [7:0]  frame_bytes[$];
    logic [15:0] crc;
    logic [7:0]  extra;
    int          n;
    frame_bytes = {frame_bytes, START_BYTE};
    frame_bytes = {frame_bytes, 8'(len)};
    repeat (5) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
    frame_bytes = {frame_bytes, id[7:0]};
    frame_bytes = {frame_bytes, id[15:8]};
    frame_bytes = {frame_bytes, id[23:16]};
    for (int j = 0; j < len; j++)
      frame_bytes = {frame_bytes,
                     (start_inside && j == 0) ? START_BYTE : 8'($urandom_range(0, 255))};
    crc = CRC_INIT;
    for (int i = 1; i < frame_bytes.size(); i++)
      crc = deframe_scoreboard::crc16_mcrf4xx(crc, frame_bytes[i]);
    if (id == sb.cfg.msg_id_a) extra = sb.cfg.crc_extra_a;
    else if (id == sb.cfg.msg_id_b) extra = sb.cfg.crc_extra_b;
    else if (id == sb.cfg.msg_id_c) extra = sb.cfg.crc_extra_c;
    else extra = 8'($urandom_range(0, 255));
    crc = deframe_scoreboard::crc16_mcrf4xx(crc, extra);
    if (bad_crc) crc ^= 16'h0001 << $urandom_range(0, 15);
    frame_bytes = {frame_bytes, crc[7:0]};
    frame_bytes = {frame_bytes, crc[15:8]};
    n = (cut >= 0 && cut < frame_bytes.size()) ? cut : frame_bytes.size();
    for (int i = 0; i < n; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic write_word(input reg_index_t idx, input logic [23:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
  endtask

  task automatic apply_config(input cfg_t c);
    write_word(REG_MSG_ID_A, c.msg_id_a);
    write_word(REG_CRC_EXTRA_A, {16'h0000, c.crc_extra_a});
    write_word(REG_MSG_ID_B, c.msg_id_b);
    write_word(REG_CRC_EXTRA_B, {16'h0000, c.crc_extra_b});
    write_word(REG_MSG_ID_C, c.msg_id_c);
    write_word(REG_CRC_EXTRA_C, {16'h0000, c.crc_extra_c});
    // indexes past the last register must not disturb anything
    write_word(REG_SPARE_6, 24'($urandom()));
    write_word(REG_SPARE_7, 24'($urandom()));
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do begin
      while (sb.pending_words.size() != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (sb.pending_words.size() != 0);
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    bit   narrow;
    narrow        = 1'($urandom_range(0, 1));
    c.msg_id_a    = narrow ? 24'($urandom_range(0, 3)) : 24'($urandom());
    c.msg_id_b    = narrow ? 24'($urandom_range(0, 3)) : 24'($urandom());
    c.msg_id_c    = narrow ? 24'($urandom_range(0, 3)) : 24'($urandom());
    c.crc_extra_a = 8'($urandom_range(0, 255));
    c.crc_extra_b = 8'($urandom_range(0, 255));
    c.crc_extra_c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  initial begin : stimulus
    cfg_t        c;
    int          len;
    int          kind;
    int          target;
    logic [23:0] kid;
    logic [23:0] uid;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= 8'h00;
    cfg_we    <= 1'b0;
    cfg_index <= REG_MSG_ID_A;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // power-on ids: noise, each slot, empty payload, start byte as data,
    // bad CRC, unknown id
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFC);
    send_frame(sb.cfg.msg_id_a, 1, 1'b0, -1, 1'b0);
    send_frame(sb.cfg.msg_id_b, 0, 1'b0, -1, 1'b0);
    send_frame(sb.cfg.msg_id_c, 3, 1'b0, -1, 1'b1);
    send_frame(sb.cfg.msg_id_a, 2, 1'b1, -1, 1'b0);
    send_frame(24'hFFFFFF, 2, 1'b0, -1, 1'b0);
    wait_idle();

    // extreme ids and extras; b shadows c
    c = '{msg_id_a: 24'h000000, crc_extra_a: 8'h00, msg_id_b: 24'hFFFFFF,
          crc_extra_b: 8'hFF, msg_id_c: 24'hFFFFFF, crc_extra_c: 8'h5A};
    apply_config(c);
    send_frame(24'h000000, 1, 1'b0, -1, 1'b0);
    send_frame(24'hFFFFFF, 0, 1'b0, -1, 1'b0);
    send_frame(24'hFFFFFF, 1, 1'b1, -1, 1'b0);
    wait_idle();

    // a shadows b
    c.msg_id_b    = 24'h000000;
    c.msg_id_c    = 24'h800001;
    c.crc_extra_c = 8'hA5;
    apply_config(c);
    send_frame(24'h000000, 0, 1'b0, -1, 1'b0);
    send_frame(24'h800001, 1, 1'b0, -1, 1'b0);
    wait_idle();

    for (int p = 0; p < 4; p++) begin
      apply_config(random_config());
      if (p == 1) begin
        hold_req = 1'b1;
        send_frame(sb.cfg.msg_id_a, 255, 1'b0, -1, 1'b0);
      end
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        kind = $urandom_range(0, 99);
        len  = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 20);
        case ($urandom_range(0, 2))
          0:       kid = sb.cfg.msg_id_a;
          1:       kid = sb.cfg.msg_id_b;
          default: kid = sb.cfg.msg_id_c;
        endcase
        do begin
          uid = $urandom_range(0, 1) ? 24'($urandom_range(0, 7)) : 24'($urandom());
        end while (uid == sb.cfg.msg_id_a || uid == sb.cfg.msg_id_b ||
                   uid == sb.cfg.msg_id_c);
        if (kind < 70)
          send_frame(kid, len, 1'b0, -1, $urandom_range(0, 3) == 0);
        else if (kind < 80)
          send_frame(kid, len, 1'b1, -1, 1'b0);
        else if (kind < 90)
          send_frame(uid, len, 1'($urandom_range(0, 1)), -1, 1'b0);
        else if (kind < 95)
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        else
          send_frame(kid, len, 1'b0, $urandom_range(1, 11 + len), 1'b0);
      end
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("PASS mavlink2_frame_checker_unit");
    end else begin
      $display("FAIL mavlink2_frame_checker_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #3000000;
    $display("FAIL mavlink2_frame_checker_unit");
    $finish;
  end

endmodule

// File: sim.f
src/mfc_pkg.sv
src/mfc_cfg_regs.sv
src/mfc_parser.sv
src/mavlink2_frame_checker_unit.sv
verif/tb.sv
